FILE: sv/alist_pkg.sv
// Shared constants, codes and types for the array list block.
`timescale 1ns / 1ps
`default_nettype none

package alist_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/alist_req_if.sv
// Request channel interface: operation, position and value.
`timescale 1ns / 1ps
`default_nettype none

interface alist_req_if import alist_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/alist_rsp_if.sv
// Response channel interface: status and result fields of one operation.
`timescale 1ns / 1ps
`default_nettype none

interface alist_rsp_if import alist_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] read_value;
   logic [POS_W-1:0]          found_position;
   logic [POS_W-1:0]          match_count;
   logic [POS_W-1:0]          entry_count;

   modport source (output valid, output status, output read_value, output found_position,
                   output match_count, output entry_count, input ready);
   modport sink   (input valid, input status, input read_value, input found_position,
                   input match_count, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/array_list_insert_delete_search_top.sv
// Ordered list store of signed 32-bit words: clear, insert, delete, search, read.
//
// The list lives in one DEPTH x 32 synchronous RAM (one read and one write port, registered
// read) plus a live entry count. One transaction is worked on at a time; the RAM read port
// sets the pace, walking one entry per cycle. Insert at position p reads count-p+1 entries,
// delete count-p, search count and read one, around the steps of decode, drain and response;
// clear and rejected operations skip the scan. The response sits in an output register, so
// a pending response does not block the next request. No clearing pass is needed after
// reset: entries at or beyond the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module array_list_insert_delete_search_top import alist_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   alist_req_if.sink   req_ch,
   alist_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // list storage
   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] mem_rdata_ff;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       left_ff, left_in;
   logic [AW-1:0]       raddr_ff, raddr_in;
   logic                pipe_v_ff, pipe_v_in;
   logic [AW-1:0]       pipe_addr_ff, pipe_addr_in;
   logic [CW-1:0]       matches_ff, matches_in;
   logic [CW-1:0]       first_ff, first_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  rd_ff, rd_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_read_ff, rsp_read_in;
   logic [POS_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]    rsp_match_ff, rsp_match_in;
   logic [POS_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                req_accept;
   logic                scan_end;
   logic                rsp_free;

   // request decode
   logic [XW-1:0]       posx, cntx;
   logic                pos_zero, is_empty, is_full, ins_bad, rng_bad;
   logic                dec_scan;
   logic [STATUS_W-1:0] dec_status;
   logic [CW-1:0]       dec_left;
   logic [AW-1:0]       dec_raddr;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign scan_end     = (left_ff == '0) && !pipe_v_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.read_value     = rsp_read_ff;
   assign rsp_ch.found_position = rsp_found_ff;
   assign rsp_ch.match_count    = rsp_match_ff;
   assign rsp_ch.entry_count    = rsp_count_ff;

   always_comb begin
      posx     = XW'(req_ch.position);
      cntx     = XW'(count_ff);
      pos_zero = (req_ch.position == '0);
      is_empty = (count_ff == '0);
      is_full  = (count_ff == FULL_COUNT);
      ins_bad  = pos_zero || (posx > cntx + XW'(1));
      rng_bad  = pos_zero || (posx > cntx);

      dec_scan   = 1'b0;
      dec_status = STATUS_OK;
      dec_left   = '0;
      dec_raddr  = '0;
      unique case (req_ch.func)
         FUNC_INSERT: begin
            if (is_full) begin
               dec_status = STATUS_FULL;
            end else if (ins_bad) begin
               dec_status = STATUS_BADPOS;
            end else begin
               // move count-pos+1 entries up, walking down from the last one
               dec_scan  = 1'b1;
               dec_left  = CW'(cntx - posx + XW'(1));
               dec_raddr = AW'(count_ff - CW'(1));
            end
         end
         FUNC_DELETE: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else if (rng_bad) begin
               dec_status = STATUS_BADPOS;
            end else begin
               // pull entries pos..count-1 down by one
               dec_scan  = 1'b1;
               dec_left  = CW'(cntx - posx);
               dec_raddr = AW'(posx);
            end
         end
         FUNC_SEARCH: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dec_scan  = 1'b1;
               dec_left  = count_ff;
               dec_raddr = '0;
            end
         end
         FUNC_READ: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else if (rng_bad) begin
               dec_status = STATUS_BADPOS;
            end else begin
               dec_scan  = 1'b1;
               dec_left  = CW'(1);
               dec_raddr = AW'(posx - XW'(1));
            end
         end
         default: begin
            // clear and unused codes finish at once
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = dec_scan ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      func_in      = func_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      raddr_in     = raddr_ff;
      pipe_v_in    = 1'b0;
      pipe_addr_in = pipe_addr_ff;
      matches_in   = matches_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_count_in  = rsp_count_ff;

      mem_re    = 1'b0;
      mem_raddr = raddr_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in    = req_ch.func;
               pos_in     = req_ch.position;
               val_in     = req_ch.value;
               left_in    = dec_left;
               raddr_in   = dec_raddr;
               matches_in = '0;
               first_in   = '0;
               rd_in      = '0;
               status_in  = dec_status;
               if (req_ch.func == FUNC_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         S_SCAN: begin
            // issue one read per cycle; the returned word is used in the next cycle
            mem_re       = (left_ff != '0);
            pipe_v_in    = mem_re;
            pipe_addr_in = raddr_ff;
            if (mem_re) begin
               left_in  = left_ff - CW'(1);
               raddr_in = (func_ff == FUNC_INSERT) ? raddr_ff - AW'(1) : raddr_ff + AW'(1);
            end
            if (pipe_v_ff) begin
               unique case (func_ff)
                  FUNC_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pipe_addr_ff + AW'(1);
                  end
                  FUNC_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pipe_addr_ff - AW'(1);
                  end
                  FUNC_SEARCH: begin
                     if (mem_rdata_ff == val_ff) begin
                        matches_in = matches_ff + CW'(1);
                        if (matches_ff == '0) begin
                           first_in = CW'(pipe_addr_ff) + CW'(1);
                        end
                     end
                  end
                  default: begin
                     rd_in = mem_rdata_ff;
                  end
               endcase
            end
            if (scan_end) begin
               unique case (func_ff)
                  FUNC_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(XW'(pos_ff) - XW'(1));
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                  end
                  FUNC_DELETE: begin
                     count_in = count_ff - CW'(1);
                  end
                  FUNC_SEARCH: begin
                     if (matches_ff == '0) begin
                        status_in = STATUS_NOTFOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_read_in   = rd_ff;
               rsp_found_in  = POS_W'(first_ff);
               rsp_match_in  = POS_W'(matches_ff);
               rsp_count_in  = POS_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pipe_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pipe_v_ff    <= pipe_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      left_ff       <= left_in;
      raddr_ff      <= raddr_in;
      pipe_addr_ff  <= pipe_addr_in;
      matches_ff    <= matches_in;
      first_ff      <= first_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

FILE: sv/alist_checker.sv
// Port-level checks for the array list block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module alist_checker import alist_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic signed [VALUE_W-1:0] rsp_read_value,
   input logic [POS_W-1:0]          rsp_found_position,
   input logic [POS_W-1:0]          rsp_match_count,
   input logic [POS_W-1:0]          rsp_entry_count
);

   // no response survives reset
   a_reset_clears_rsp: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // one transaction at a time: an accepted request closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another transaction is in work");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == STATUS_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with nonzero entry count");

   a_results_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0 || rsp_match_count != '0 ||
                    rsp_found_position != '0) |-> rsp_status == STATUS_OK)
      else $error("result data carried on a failed operation");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 255) || (int'(rsp_entry_count) <= DEPTH))
      else $error("entry count above list depth");

endmodule

bind array_list_insert_delete_search_top alist_checker #(.DEPTH(DEPTH)) u_alist_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_read_value     (rsp_ch.read_value),
   .rsp_found_position (rsp_ch.found_position),
   .rsp_match_count    (rsp_ch.match_count),
   .rsp_entry_count    (rsp_ch.entry_count)
);

`default_nettype wire

FILE: sim/tb_array_list_insert_delete_search_top.sv
// Self-checking testbench for the array list block: shadow list, directed and random traffic.
`timescale 1ns / 1ps

typedef struct packed {
   logic [alist_pkg::STATUS_W-1:0]       status;
   logic signed [alist_pkg::VALUE_W-1:0] read_value;
   logic [alist_pkg::POS_W-1:0]          found_position;
   logic [alist_pkg::POS_W-1:0]          match_count;
   logic [alist_pkg::POS_W-1:0]          entry_count;
} alist_outcome_type;

// Shadow copy of the list; each accepted request is applied here and its response queued.
class list_shadow;
   logic signed [alist_pkg::VALUE_W-1:0] list_mem [alist_pkg::DEPTH_DEFAULT];
   int                list_len;
   int                errors;
   alist_outcome_type owed_responses[$];

   function new();
      list_len = 0;
      errors   = 0;
      foreach (list_mem[i]) list_mem[i] = '0;
   endfunction

   function int pending();
      return owed_responses.size();
   endfunction

   function void apply_op(logic [alist_pkg::FUNC_W-1:0] func,
                          logic [alist_pkg::POS_W-1:0] pos,
                          logic signed [alist_pkg::VALUE_W-1:0] val);
      alist_outcome_type r;
      int p;
      int i;
      int hits;
      r = '0;
      p = int'(pos);
      hits = 0;
      case (func)
         alist_pkg::FUNC_CLEAR: begin
            list_len = 0;
         end
         alist_pkg::FUNC_INSERT: begin
            if (list_len >= alist_pkg::DEPTH_DEFAULT) begin
               r.status = alist_pkg::STATUS_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               r.status = alist_pkg::STATUS_BADPOS;
            end else begin
               for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
               list_mem[p-1] = val;
               list_len++;
            end
         end
         alist_pkg::FUNC_DELETE: begin
            if (list_len == 0) begin
               r.status = alist_pkg::STATUS_EMPTY;
            end else if (p < 1 || p > list_len) begin
               r.status = alist_pkg::STATUS_BADPOS;
            end else begin
               for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         alist_pkg::FUNC_SEARCH: begin
            if (list_len == 0) begin
               r.status = alist_pkg::STATUS_EMPTY;
            end else begin
               for (i = 0; i < list_len; i++) begin
                  if (list_mem[i] == val) begin
                     if (hits == 0) r.found_position = alist_pkg::POS_W'(i + 1);
                     hits++;
                  end
               end
               r.match_count = alist_pkg::POS_W'(hits);
               if (hits == 0) r.status = alist_pkg::STATUS_NOTFOUND;
            end
         end
         alist_pkg::FUNC_READ: begin
            if (list_len == 0) begin
               r.status = alist_pkg::STATUS_EMPTY;
            end else if (p < 1 || p > list_len) begin
               r.status = alist_pkg::STATUS_BADPOS;
            end else begin
               r.read_value = list_mem[p-1];
            end
         end
         default: ;  // codes 5..7 leave the list alone
      endcase
      r.entry_count = alist_pkg::POS_W'(list_len);
      owed_responses.push_back(r);
   endfunction

   function void match_response(alist_outcome_type got);
      alist_outcome_type want;
      if (owed_responses.size() == 0) begin
         $error("response with no transaction outstanding");
         errors++;
         return;
      end
      want = owed_responses.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.read_value !== want.read_value) begin
         $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
         errors++;
      end
      if (got.found_position !== want.found_position) begin
         $error("found_position: expected %0d, got %0d", want.found_position,
                got.found_position);
         errors++;
      end
      if (got.match_count !== want.match_count) begin
         $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
         errors++;
      end
      if (got.entry_count !== want.entry_count) begin
         $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
         errors++;
      end
   endfunction
endclass

module tb_array_list_insert_delete_search_top;
   import alist_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
   localparam int TIMEOUT_NS   = 30_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   alist_req_if req_bus ();
   alist_rsp_if rsp_bus ();

   list_shadow board = new();

   int items_sent = 0;
   bit req_quiet  = 1'b0;
   bit rsp_quiet  = 1'b0;

   array_list_insert_delete_search_top #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #10 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // Responses are taken at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      alist_outcome_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status         = rsp_bus.status;
         got.read_value     = rsp_bus.read_value;
         got.found_position = rsp_bus.found_position;
         got.match_count    = rsp_bus.match_count;
         got.entry_count    = rsp_bus.entry_count;
         board.match_response(got);
      end
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $signed($urandom_range(0, 7)) - 4;  // small pool for duplicates
      if (r < 40) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_pos(int upper);
      if (upper >= 1 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(1, upper));
      return POS_W'($urandom_range(0, 255));
   endfunction

   task automatic send_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                          input logic signed [VALUE_W-1:0] v);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.func     = f;
      req_bus.position = p;
      req_bus.value    = v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.apply_op(f, p, v);
      items_sent++;
   endtask

   // clear, then append entries one by one
   task automatic load_list(input int target, input bit uniform);
      logic signed [VALUE_W-1:0] fill;
      fill = pick_value();
      send_op(FUNC_CLEAR, POS_W'($urandom_range(0, 255)), $urandom);
      for (int k = 0; k < target; k++)
         send_op(FUNC_INSERT, POS_W'(board.list_len + 1), uniform ? fill : pick_value());
   endtask

   task automatic random_op();
      int w;
      logic signed [VALUE_W-1:0] key;
      w = $urandom_range(0, 99);
      if (w < 35) begin
         send_op(FUNC_INSERT, pick_pos(board.list_len + 1), pick_value());
      end else if (w < 55) begin
         send_op(FUNC_DELETE, pick_pos(board.list_len), $urandom);
      end else if (w < 72) begin
         if (board.list_len > 0 && $urandom_range(0, 99) < 60)
            key = board.list_mem[$urandom_range(0, board.list_len - 1)];
         else
            key = pick_value();
         send_op(FUNC_SEARCH, POS_W'($urandom_range(0, 255)), key);
      end else if (w < 92) begin
         send_op(FUNC_READ, pick_pos(board.list_len), $urandom);
      end else if (w < 95) begin
         send_op(FUNC_CLEAR, POS_W'($urandom_range(0, 255)), $urandom);
      end else begin
         send_op(FUNC_W'($urandom_range(5, 7)), POS_W'($urandom_range(0, 255)), $urandom);
      end
   endtask

   initial begin
      int hold;
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold  = $urandom_range(1, 8);
         stall = pick_gap(rsp_quiet);
         rsp_bus.ready = 1'b1;
         repeat (hold) @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
      end
   end

   initial begin
      int target;
      req_bus.valid    = 1'b0;
      req_bus.func     = FUNC_CLEAR;
      req_bus.position = '0;
      req_bus.value    = '0;
      reset = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty list, bad positions, extremes, duplicates, unused codes
      send_op(FUNC_SEARCH, 8'd0,   32'sd5);
      send_op(FUNC_READ,   8'd1,   32'sd0);
      send_op(FUNC_DELETE, 8'd1,   32'sd0);
      send_op(FUNC_INSERT, 8'd0,   32'sd9);
      send_op(FUNC_INSERT, 8'd2,   32'sd9);
      send_op(FUNC_INSERT, 8'd1,   32'sh8000_0000);
      send_op(FUNC_INSERT, 8'd2,   32'sh7FFF_FFFF);
      send_op(FUNC_INSERT, 8'd1,   -32'sd1);
      send_op(FUNC_INSERT, 8'd2,   32'sh8000_0000);
      send_op(FUNC_SEARCH, 8'd0,   32'sh8000_0000);
      send_op(FUNC_SEARCH, 8'd255, 32'sd12345);
      send_op(FUNC_READ,   8'd4,   32'sd0);
      send_op(FUNC_READ,   8'd0,   32'sd0);
      send_op(FUNC_READ,   8'd255, 32'sd0);
      send_op(FUNC_READ,   8'd5,   32'sd0);
      send_op(FUNC_DELETE, 8'd5,   32'sd0);
      send_op(FUNC_DELETE, 8'd0,   32'sd0);
      send_op(FUNC_DELETE, 8'd4,   32'sd0);
      send_op(FUNC_DELETE, 8'd1,   32'sd0);
      send_op(3'd5,        8'd0,   32'sd0);
      send_op(3'd6,        8'd128, 32'sh7FFF_FFFF);
      send_op(3'd7,        8'd255, -32'sd1);
      send_op(FUNC_INSERT, 8'd255, 32'sd0);
      send_op(FUNC_CLEAR,  8'd0,   32'sd0);
      send_op(FUNC_READ,   8'd1,   32'sd0);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 6) begin
            if ($urandom_range(0, 3) == 0) begin
               // full list: overflow insert, then search for the head entry
               load_list(DEPTH, $urandom_range(0, 4) == 0);
               send_op(FUNC_INSERT, pick_pos(DEPTH + 1), pick_value());
               send_op(FUNC_SEARCH, POS_W'($urandom_range(0, 255)), board.list_mem[0]);
            end else begin
               load_list($urandom_range(1, 16), $urandom_range(0, 4) == 0);
            end
         end else begin
            random_op();
         end
         if ($urandom_range(0, 149) == 0) req_quiet = ~req_quiet;
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: sim.f
sv/alist_pkg.sv
sv/alist_req_if.sv
sv/alist_rsp_if.sv
sv/array_list_insert_delete_search_top.sv
sv/alist_checker.sv
sim/tb_array_list_insert_delete_search_top.sv
